// ----- rtl/prg_pkg.sv -----
package prg_pkg;

   localparam int DATA_WIDTH_DEFAULT = 32;

   // Cosine and sine carry 30 fraction bits in a 32-bit signed field.
   localparam int CS_FRAC = 30;
   localparam int CS_W = 32;
   localparam int CS_MAG_W = CS_FRAC + 1;

   // The squared ratio is formed with 2*CS_FRAC+2 fraction bits, so that
   // its root carries one guard bit below the cosine's last bit.
   localparam int QUO_W = 2 * CS_FRAC + 2;
   localparam int QROOT_W = QUO_W / 2;

   localparam logic [CS_MAG_W-1:0] CS_ONE = CS_MAG_W'(1) << CS_FRAC;

endpackage

// ----- rtl/prg_isqrt.sv -----
module prg_isqrt #(
   parameter int N = 32,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [2*N-1:0]    in_radicand,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [N-1:0]      out_root,
   output logic [N:0]        out_rem,
   output logic [SIDE_W-1:0] out_side
);

   // One root bit is resolved per stage, two radicand bits at a time from the top.
   logic              vld_ff  [N];
   logic [2*N-1:0]    x_ff    [N];
   logic [N-1:0]      root_ff [N];
   logic [N:0]        rem_ff  [N];
   logic [SIDE_W-1:0] side_ff [N];

   genvar k;
   for (k = 0; k < N; k++) begin : g_step
      logic              v_in;
      logic [2*N-1:0]    x_in;
      logic [N-1:0]      root_in;
      logic [N:0]        rem_in;
      logic [SIDE_W-1:0] side_in;
      logic [N+2:0]      rem_t;
      logic [N+2:0]      trial;
      logic [N-1:0]      root_nx;
      logic [N:0]        rem_nx;

      if (k == 0) begin : g_first
         assign v_in    = in_valid;
         assign x_in    = in_radicand;
         assign root_in = '0;
         assign rem_in  = '0;
         assign side_in = in_side;
      end else begin : g_next
         assign v_in    = vld_ff[k-1];
         assign x_in    = x_ff[k-1];
         assign root_in = root_ff[k-1];
         assign rem_in  = rem_ff[k-1];
         assign side_in = side_ff[k-1];
      end

      always_comb begin
         rem_t = {rem_in, x_in[2*N-1:2*N-2]};
         trial = {1'b0, root_in, 2'b01};
         if (rem_t >= trial) begin
            rem_nx  = (N+1)'(rem_t - trial);
            root_nx = {root_in[N-2:0], 1'b1};
         end else begin
            rem_nx  = rem_t[N:0];
            root_nx = {root_in[N-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= v_in;
         end
         x_ff[k]    <= {x_in[2*N-3:0], 2'b00};
         root_ff[k] <= root_nx;
         rem_ff[k]  <= rem_nx;
         side_ff[k] <= side_in;
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_rem   = rem_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

// ----- rtl/plane_rotation_generator_top.sv -----
// Channel    Ports                                           Handshake
// request    req_f_value, req_g_value, req_last_pair         start (busy stays low)
// response   rsp_cosine, rsp_sine, rsp_radius,               rsp_valid, one cycle
//            rsp_last_rotation
//
// A request can be taken in every cycle; busy is always low.
// The response path runs through the 62-stage restoring divider followed by the
// pipelined square roots.
// Synchronous reset clears only the valid bits, so requests in flight are dropped.
// The receiver cannot stall; each response is shown for exactly one cycle.
module plane_rotation_generator_top #(
   parameter int DATA_WIDTH = prg_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [DATA_WIDTH-1:0]  req_f_value,
   input  logic signed [DATA_WIDTH-1:0]  req_g_value,
   input  logic                          req_last_pair,
   output logic                          rsp_valid,
   output logic signed [prg_pkg::CS_W-1:0] rsp_cosine,
   output logic signed [prg_pkg::CS_W-1:0] rsp_sine,
   output logic signed [DATA_WIDTH:0]    rsp_radius,
   output logic                          rsp_last_rotation
);
   import prg_pkg::*;

   localparam int W = DATA_WIDTH;
   localparam int SW = 2 * W;
   localparam int NS = (W > QROOT_W) ? W : QROOT_W;
   localparam int LATENCY = 69 + NS;

   typedef struct packed {
      logic         last;
      logic         spec;
      logic         gzero;
      logic         cneg;
      logic         sneg;
      logic         rneg;
      logic [W-1:0] spec_mag;
   } side_type;

   localparam int SIDE_W = $bits(side_type);

   assign busy = 1'b0;

   // Input register.
   logic         v0_ff;
   logic [W-1:0] f0_ff, g0_ff;
   logic         last0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
      end
      f0_ff    <= req_f_value;
      g0_ff    <= req_g_value;
      last0_ff <= req_last_pair;
   end

   // Magnitudes; the most negative input yields 2^(W-1) in W unsigned bits.
   logic         v1_ff;
   logic [W-1:0] fm1_ff, gm1_ff, fm1_in, gm1_in;
   logic         fneg1_ff, gneg1_ff, last1_ff;

   always_comb begin
      fm1_in = f0_ff[W-1] ? W'(-f0_ff) : f0_ff;
      gm1_in = g0_ff[W-1] ? W'(-g0_ff) : g0_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
      fm1_ff   <= fm1_in;
      gm1_ff   <= gm1_in;
      fneg1_ff <= f0_ff[W-1];
      gneg1_ff <= g0_ff[W-1];
      last1_ff <= last0_ff;
   end

   // Squares, and the sign and special-case decisions.
   logic          v2_ff;
   logic [SW-1:0] fsq2_ff, gsq2_ff;
   side_type      side2_ff, side2_in;

   always_comb begin
      logic gz, fz, prod_neg;
      gz       = (gm1_ff == '0);
      fz       = (fm1_ff == '0);
      prod_neg = fneg1_ff ^ gneg1_ff;
      side2_in.last     = last1_ff;
      side2_in.spec     = gz || fz;
      side2_in.gzero    = gz;
      side2_in.spec_mag = gz ? fm1_ff : gm1_ff;
      if (gz) begin
         side2_in.cneg = 1'b0;
         side2_in.sneg = 1'b0;
         side2_in.rneg = fneg1_ff;
      end else if (fz) begin
         side2_in.cneg = 1'b0;
         side2_in.sneg = 1'b0;
         side2_in.rneg = gneg1_ff;
      end else if (fm1_ff > gm1_ff) begin
         side2_in.cneg = 1'b0;
         side2_in.sneg = prod_neg;
         side2_in.rneg = fneg1_ff;
      end else begin
         side2_in.cneg = prod_neg;
         side2_in.sneg = 1'b0;
         side2_in.rneg = gneg1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      fsq2_ff  <= SW'(fm1_ff) * SW'(fm1_ff);
      gsq2_ff  <= SW'(gm1_ff) * SW'(gm1_ff);
      side2_ff <= side2_in;
   end

   // Sum of squares; it never exceeds 2^(2W-1).
   logic          v3_ff;
   logic [SW-1:0] sum3_ff, fsq3_ff;
   side_type      side3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      sum3_ff  <= fsq2_ff + gsq2_ff;
      fsq3_ff  <= fsq2_ff;
      side3_ff <= side2_ff;
   end

   // Restoring divider: quotient of f^2 * 2^QUO_W by the sum, one bit a stage.
   // In the general case f^2 is below the sum, so the quotient fits QUO_W bits.
   logic             dv_ff  [QUO_W];
   logic [SW-1:0]    drem_ff[QUO_W];
   logic [SW-1:0]    dden_ff[QUO_W];
   logic [QUO_W-1:0] dquo_ff[QUO_W];
   side_type         dside_ff[QUO_W];

   genvar k;
   for (k = 0; k < QUO_W; k++) begin : g_div
      logic             v_in;
      logic [SW-1:0]    rem_in, den_in;
      logic [QUO_W-1:0] quo_in;
      side_type         side_in;
      logic [SW:0]      rem2;
      logic [SW-1:0]    rem_nx;
      logic             bit_nx;

      if (k == 0) begin : g_first
         assign v_in    = v3_ff;
         assign rem_in  = fsq3_ff;
         assign den_in  = sum3_ff;
         assign quo_in  = '0;
         assign side_in = side3_ff;
      end else begin : g_next
         assign v_in    = dv_ff[k-1];
         assign rem_in  = drem_ff[k-1];
         assign den_in  = dden_ff[k-1];
         assign quo_in  = dquo_ff[k-1];
         assign side_in = dside_ff[k-1];
      end

      always_comb begin
         rem2 = {rem_in, 1'b0};
         if (rem2 >= {1'b0, den_in}) begin
            rem_nx = SW'(rem2 - {1'b0, den_in});
            bit_nx = 1'b1;
         end else begin
            rem_nx = rem2[SW-1:0];
            bit_nx = 1'b0;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k] <= 1'b0;
         end else begin
            dv_ff[k] <= v_in;
         end
         drem_ff[k]  <= rem_nx;
         dden_ff[k]  <= den_in;
         dquo_ff[k]  <= {quo_in[QUO_W-2:0], bit_nx};
         dside_ff[k] <= side_in;
      end
   end

   // The squared sine is one minus the squared cosine, taken as a floor.
   logic             v4_ff;
   logic [QUO_W-1:0] qf4_ff, qg4_ff, qg4_in;
   logic [SW-1:0]    sum4_ff;
   side_type         side4_ff;

   assign qg4_in = QUO_W'(({1'b1, {QUO_W{1'b0}}}) - {1'b0, dquo_ff[QUO_W-1]}
                          - (QUO_W+1)'(drem_ff[QUO_W-1] != '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= dv_ff[QUO_W-1];
      end
      qf4_ff   <= dquo_ff[QUO_W-1];
      qg4_ff   <= qg4_in;
      sum4_ff  <= dden_ff[QUO_W-1];
      side4_ff <= dside_ff[QUO_W-1];
   end

   // Three square roots in lockstep.
   logic          rv_s, cv_s, sv_s;
   logic [NS-1:0] rroot_s, croot_s, sroot_s;
   logic [NS:0]   rrem_s;
   side_type      rside_s;
   logic [5:0]    cside_s;
   logic          sside_s;

   prg_isqrt #(.N(NS), .SIDE_W(SIDE_W)) u_root_r (
      .clock(clock), .reset(reset), .in_valid(v4_ff),
      .in_radicand((2*NS)'(sum4_ff)), .in_side(side4_ff),
      .out_valid(rv_s), .out_root(rroot_s), .out_rem(rrem_s), .out_side(rside_s)
   );

   prg_isqrt #(.N(NS), .SIDE_W(6)) u_root_c (
      .clock(clock), .reset(reset), .in_valid(v4_ff),
      .in_radicand((2*NS)'(qf4_ff)), .in_side(6'(0)),
      .out_valid(cv_s), .out_root(croot_s), .out_rem(), .out_side(cside_s)
   );

   prg_isqrt #(.N(NS), .SIDE_W(1)) u_root_s (
      .clock(clock), .reset(reset), .in_valid(v4_ff),
      .in_radicand((2*NS)'(qg4_ff)), .in_side(1'b0),
      .out_valid(sv_s), .out_root(sroot_s), .out_rem(), .out_side(sside_s)
   );

   // Rounding and special cases.
   logic                v5_ff;
   logic [CS_MAG_W-1:0] cm5_ff, sm5_ff, cm5_in, sm5_in;
   logic [W-1:0]        rm5_ff, rm5_in;
   side_type            side5_ff;

   always_comb begin
      logic [CS_MAG_W:0] cr, sr;
      logic [NS:0]       rr;
      cr = (CS_MAG_W+1)'(croot_s[QROOT_W-1:0]) + (CS_MAG_W+1)'(1);
      sr = (CS_MAG_W+1)'(sroot_s[QROOT_W-1:0]) + (CS_MAG_W+1)'(1);
      rr = {1'b0, rroot_s} + (NS+1)'(rrem_s > {1'b0, rroot_s});
      if (rside_s.spec) begin
         cm5_in = rside_s.gzero ? CS_ONE : '0;
         sm5_in = rside_s.gzero ? '0 : CS_ONE;
         rm5_in = rside_s.spec_mag;
      end else begin
         cm5_in = cr[CS_MAG_W:1];
         sm5_in = sr[CS_MAG_W:1];
         rm5_in = rr[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= rv_s && cv_s && sv_s && (cside_s == '0) && !sside_s;
      end
      cm5_ff   <= cm5_in;
      sm5_ff   <= sm5_in;
      rm5_ff   <= rm5_in;
      side5_ff <= rside_s;
   end

   // Signs and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= v5_ff;
      end
      rsp_cosine <= side5_ff.cneg ? CS_W'(-{1'b0, cm5_ff}) : CS_W'({1'b0, cm5_ff});
      rsp_sine   <= side5_ff.sneg ? CS_W'(-{1'b0, sm5_ff}) : CS_W'({1'b0, sm5_ff});
      rsp_radius <= side5_ff.rneg ? (W+1)'(-{1'b0, rm5_ff}) : (W+1)'({1'b0, rm5_ff});
      rsp_last_rotation <= side5_ff.last;
   end

   // A response appears exactly the pipeline latency after its request.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("response without a matching request");

   a_cos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cosine <= $signed(CS_W'(CS_ONE)))
                 && (rsp_cosine >= -$signed(CS_W'(CS_ONE))))
      else $error("cosine out of range");

   // A zero radius only comes from a zero pair, which gives the identity rotation.
   a_zero_pair: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_radius == '0) |-> (rsp_cosine == CS_W'(CS_ONE) && rsp_sine == '0))
      else $error("zero pair did not give the identity rotation");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import prg_pkg::*;

   localparam int DW = 32;
   localparam int LATENCY = 69 + DW;
   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_ITEMS = 1400;

   typedef struct {
      logic signed [DW-1:0] f_value;
      logic signed [DW-1:0] g_value;
      logic                 last_pair;
      logic                 drain_first;
   } pair_req_t;

   typedef struct {
      logic signed [CS_W-1:0] cosine;
      logic signed [CS_W-1:0] sine;
      logic signed [DW:0]     radius;
      logic                   last_rotation;
   } rotation_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [DW-1:0] req_f_value = '0;
   logic signed [DW-1:0] req_g_value = '0;
   logic req_last_pair = 1'b0;
   logic rsp_valid;
   logic signed [CS_W-1:0] rsp_cosine;
   logic signed [CS_W-1:0] rsp_sine;
   logic signed [DW:0] rsp_radius;
   logic rsp_last_rotation;

   pair_req_t pending_pairs[$];
   rotation_t expected_rotations[$];
   int errors = 0;
   int requests_sent = 0;
   int responses_seen = 0;
   int total_requests = 0;
   int cycle_count = 0;

   plane_rotation_generator_top #(.DATA_WIDTH(DW)) i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_f_value(req_f_value), .req_g_value(req_g_value),
      .req_last_pair(req_last_pair), .rsp_valid(rsp_valid),
      .rsp_cosine(rsp_cosine), .rsp_sine(rsp_sine), .rsp_radius(rsp_radius),
      .rsp_last_rotation(rsp_last_rotation)
   );

   always #4 clock = ~clock;

   // Nearest integer to mag * 2^30 / sqrt(sum), ties away from zero, found by
   // bisection on (2k-1)^2 * sum <= mag^2 * 2^62.
   function automatic logic [63:0] scaled_ratio(input logic [159:0] mag,
                                                input logic [159:0] sum);
      logic [159:0] lo;
      logic [159:0] hi;
      logic [159:0] mid;
      logic [159:0] odd;
      logic [159:0] bound;
      lo = 0;
      hi = 160'd1 << CS_FRAC;
      bound = (mag * mag) << (2 * CS_FRAC + 2);
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         odd = 2 * mid - 1;
         if (odd * odd * sum <= bound) lo = mid;
         else hi = mid - 1;
      end
      return lo[63:0];
   endfunction

   function automatic logic [63:0] nearest_root(input logic [159:0] sum);
      logic [159:0] lo;
      logic [159:0] hi;
      logic [159:0] mid;
      lo = 0;
      hi = 160'd1 << DW;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         if (mid * mid <= sum) lo = mid;
         else hi = mid - 1;
      end
      if (sum > lo * lo + lo) lo = lo + 1;
      return lo[63:0];
   endfunction

   function automatic rotation_t givens_rotation(input pair_req_t p);
      rotation_t rot;
      logic signed [63:0] fs;
      logic signed [63:0] gs;
      logic [63:0] fm;
      logic [63:0] gm;
      logic [63:0] cm;
      logic [63:0] sm;
      logic [63:0] rm;
      logic [159:0] sum;
      logic fneg;
      logic gneg;
      logic cneg;
      logic sneg;
      logic rneg;
      fs = p.f_value;
      gs = p.g_value;
      fneg = fs < 0;
      gneg = gs < 0;
      fm = fneg ? -fs : fs;
      gm = gneg ? -gs : gs;
      if (gm == 0) begin
         cm = 64'd1 << CS_FRAC; sm = 0; rm = fm;
         cneg = 0; sneg = 0; rneg = fneg;
      end else if (fm == 0) begin
         cm = 0; sm = 64'd1 << CS_FRAC; rm = gm;
         cneg = 0; sneg = 0; rneg = gneg;
      end else begin
         sum = 160'(fm) * 160'(fm) + 160'(gm) * 160'(gm);
         cm = scaled_ratio(160'(fm), sum);
         sm = scaled_ratio(160'(gm), sum);
         rm = nearest_root(sum);
         // The sign of the larger element is moved into the radius.
         if (fm > gm) begin
            cneg = 0; sneg = fneg != gneg; rneg = fneg;
         end else begin
            cneg = fneg != gneg; sneg = 0; rneg = gneg;
         end
      end
      rot.cosine = cneg ? -cm[CS_W-1:0] : cm[CS_W-1:0];
      rot.sine = sneg ? -sm[CS_W-1:0] : sm[CS_W-1:0];
      rot.radius = rneg ? -rm[DW:0] : rm[DW:0];
      rot.last_rotation = p.last_pair;
      return rot;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      errors++;
      $display("response %0d: %s got %h expected %h", responses_seen, what, got, want);
   endtask

   function automatic int idle_percent(input int sent);
      int q;
      q = sent * 4 / (total_requests + 1);
      case (q)
         0: return 0;
         1: return 54;
         2: return 23;
         default: return (sent % 200 < 100) ? 0 : 54;
      endcase
   endfunction

   // Driver: a request is taken at an edge where start is high and busy low.
   always @(posedge clock) begin
      pair_req_t nxt;
      logic go;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            pair_req_t cur;
            cur.f_value = req_f_value;
            cur.g_value = req_g_value;
            cur.last_pair = req_last_pair;
            cur.drain_first = 1'b0;
            expected_rotations.push_back(givens_rotation(cur));
            requests_sent++;
         end
         go = 1'b0;
         if (start && busy) begin
            go = 1'b1;
         end else if (pending_pairs.size() > 0 &&
                      $urandom_range(99) >= idle_percent(requests_sent)) begin
            nxt = pending_pairs[0];
            if (!(nxt.drain_first && expected_rotations.size() > 0 &&
                  !(start && !busy))) begin
               if (!(nxt.drain_first && start && !busy)) begin
                  void'(pending_pairs.pop_front());
                  req_f_value <= nxt.f_value;
                  req_g_value <= nxt.g_value;
                  req_last_pair <= nxt.last_pair;
                  go = 1'b1;
               end
            end
         end
         start <= go;
      end
   end

   always @(posedge clock) begin
      rotation_t want;
      if (!reset && rsp_valid) begin
         responses_seen++;
         if (expected_rotations.size() == 0) begin
            errors++;
            $display("response %0d arrived with nothing outstanding", responses_seen);
         end else begin
            want = expected_rotations.pop_front();
            if (rsp_cosine !== want.cosine)
               report_mismatch("cosine", 64'(rsp_cosine), 64'(want.cosine));
            if (rsp_sine !== want.sine)
               report_mismatch("sine", 64'(rsp_sine), 64'(want.sine));
            if (rsp_radius !== want.radius)
               report_mismatch("radius", 64'(rsp_radius), 64'(want.radius));
            if (rsp_last_rotation !== want.last_rotation)
               report_mismatch("last_rotation", 64'(rsp_last_rotation),
                               64'(want.last_rotation));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic add_pair(input logic signed [DW-1:0] f, input logic signed [DW-1:0] g,
                           input logic last, input logic drain);
      pair_req_t p;
      p.f_value = f;
      p.g_value = g;
      p.last_pair = last;
      p.drain_first = drain;
      pending_pairs.push_back(p);
   endtask

   function automatic logic signed [DW-1:0] random_element();
      logic signed [DW-1:0] v;
      v = $urandom;
      case ($urandom_range(9))
         0: v = '0;
         1: v = v >>> $urandom_range(DW - 1);
         2: v = {1'b1, {(DW - 1){1'b0}}};
         3: v = {1'b0, {(DW - 1){1'b1}}};
         4: v = $signed(32'($urandom_range(8))) - 4;
         default: ;
      endcase
      return v;
   endfunction

   initial begin
      logic signed [DW-1:0] a;
      logic signed [DW-1:0] b;
      localparam logic signed [DW-1:0] MOST_NEG = {1'b1, {(DW - 1){1'b0}}};
      localparam logic signed [DW-1:0] MOST_POS = {1'b0, {(DW - 1){1'b1}}};
      add_pair(0, 0, 0, 0);
      add_pair(0, 0, 1, 0);
      add_pair(32'sh10000, 0, 0, 0);
      add_pair(-32'sh10000, 0, 0, 0);
      add_pair(0, 32'sh10000, 0, 0);
      add_pair(0, -32'sh30000, 1, 0);
      add_pair(MOST_NEG, 0, 0, 0);
      add_pair(0, MOST_NEG, 0, 0);
      add_pair(MOST_NEG, MOST_NEG, 0, 0);
      add_pair(MOST_POS, MOST_POS, 1, 0);
      add_pair(MOST_POS, MOST_NEG, 0, 0);
      add_pair(MOST_NEG, MOST_POS, 0, 0);
      add_pair(5, 5, 0, 0);
      add_pair(-5, 5, 0, 0);
      add_pair(5, -5, 0, 0);
      add_pair(-5, -5, 1, 0);
      add_pair(3, 4, 0, 0);
      add_pair(-4, 3, 0, 0);
      add_pair(1, -1, 0, 0);
      add_pair(1, MOST_POS, 0, 0);
      add_pair(MOST_NEG, -1, 1, 0);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         a = random_element();
         b = random_element();
         // Equal magnitudes decide which element carries the sign.
         if ($urandom_range(19) == 0) b = $urandom_range(1) ? a : -a;
         add_pair(a, b, $urandom_range(7) == 0, i == RANDOM_ITEMS / 3);
      end
      total_requests = pending_pairs.size();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (pending_pairs.size() != 0 || start || expected_rotations.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      $display("%0d pairs sent, %0d rotations checked, covering zeros, extremes, ties",
               requests_sent, responses_seen);
      $display("and random pairs under no, light and heavy request gaps.");
      if (errors == 0 && expected_rotations.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d errors, %0d rotations outstanding", errors,
                  expected_rotations.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/prg_pkg.sv
rtl/prg_isqrt.sv
rtl/plane_rotation_generator_top.sv
verif/testbench.sv
